// ===== hdl/dep_pkg.sv =====
// ----------------------------------------------------------------------------
// dep_pkg
// Shared types and constants of the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int RES_BITS   = 3 * VALUE_BITS + CNT_W + 1;
    localparam int RES_W      = ((RES_BITS + 7) / 8) * 8;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_INSERT  = 3'd0;
    localparam t_kind KIND_EXT_MIN = 3'd1;
    localparam t_kind KIND_EXT_MAX = 3'd2;
    localparam t_kind KIND_CLEAR   = 3'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_INS, OP_FULL, OP_EMPTY, OP_CLR,
        OP_UPSET, OP_DNSET, OP_PICK, OP_W1, OP_XW1, OP_W2,
        OP_XSET, OP_YSET, OP_DEC, OP_UPO, OP_HISET, OP_TOP, OP_OUT
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_UP_SET, S_UP_RD, S_UP_EV, S_UP_W2,
        S_DN_SET, S_DN_RD1, S_DN_PICK, S_DN_RD2, S_DN_EV, S_DN_W2,
        S_X_SET, S_X_RD, S_X_W1, S_X_W2,
        S_Y_SET, S_Y_RD, S_Y_W1, S_Y_W2,
        S_X_DEC, S_UPO, S_HI_SET,
        S_FIN, S_FIN_RD, S_FIN_OUT
    } t_state;

    typedef enum logic [1:0] {
        STG_INS_LOW, STG_INS_HIGH, STG_EXT
    } t_stage;

    typedef struct packed {
        t_dp_op op;
        logic   rd;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  empty;
        logic  full;
        logic  up_go;
        logic  dn_go;
        logic  swap_up;
        logic  swap_dn;
        logic  out_free;
    } t_dp_sts;

endpackage

// ===== hdl/dep_datapath.sv =====
// ----------------------------------------------------------------------------
// dep_datapath
// Heap memories, link memories, position registers and result register.
// ----------------------------------------------------------------------------
module dep_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dep_pkg::t_dp_cmd              i_cmd,
    output dep_pkg::t_dp_sts              o_sts,
    input  dep_pkg::t_kind                i_kind,
    input  logic [dep_pkg::VALUE_BITS-1:0] i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output dep_pkg::t_status              o_out_status,
    output logic [dep_pkg::RES_W-1:0]     o_out_data
);
    import dep_pkg::*;

    logic [VALUE_BITS-1:0] r_val [2][CAPACITY];
    logic [ADDR_W-1:0]     r_lnk [2][CAPACITY];
    logic [VALUE_BITS-1:0] r_qav [2];
    logic [VALUE_BITS-1:0] r_qbv [2];
    logic [ADDR_W-1:0]     r_qal [2];
    logic [ADDR_W-1:0]     r_qbl [2];

    logic [CNT_W-1:0]      r_count;
    logic                  r_out_valid;
    t_kind                 r_kind;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_xs;
    logic                  r_hs;
    logic [ADDR_W-1:0]     r_a;
    logic [ADDR_W-1:0]     r_b;
    logic [ADDR_W-1:0]     r_cur;
    logic [ADDR_W-1:0]     r_other;
    logic                  r_c2ok;
    t_status               r_status;
    logic [VALUE_BITS-1:0] r_removed;
    t_status               r_out_status;
    logic [RES_W-1:0]      r_out_data;

    logic                  val_we [2];
    logic [ADDR_W-1:0]     val_wa [2];
    logic [VALUE_BITS-1:0] val_wd [2];
    logic                  lnk_we [2];
    logic [ADDR_W-1:0]     lnk_wa [2];
    logic [ADDR_W-1:0]     lnk_wd [2];

    logic [VALUE_BITS-1:0] a_v;
    logic [VALUE_BITS-1:0] b_v;
    logic [ADDR_W-1:0]     a_l;
    logic [CNT_W-1:0]      c1;
    logic [CNT_W:0]        c2;
    logic [ADDR_W-1:0]     cur_m1;
    logic [ADDR_W-1:0]     parent;
    logic [ADDR_W-1:0]     cnt_m1;
    logic [ADDR_W-1:0]     pick;
    logic                  is_w1;
    logic                  is_w2;
    logic                  out_free;

    function automatic logic better(input logic [VALUE_BITS-1:0] x,
                                    input logic [VALUE_BITS-1:0] y,
                                    input logic                  hi);
        logic res;
        res = hi ? ($signed(x) > $signed(y)) : ($signed(x) < $signed(y));
        return res;
    endfunction

    always_comb begin
        a_v      = r_qav[r_hs];
        b_v      = r_qbv[r_hs];
        a_l      = r_qal[r_hs];
        c1       = {r_cur, 1'b1};
        c2       = {1'b0, r_cur, 1'b0} + (CNT_W+1)'(2);
        cur_m1   = r_cur - ADDR_W'(1);
        parent   = {1'b0, cur_m1[ADDR_W-1:1]};
        cnt_m1   = ADDR_W'(r_count - CNT_W'(1));
        pick     = (r_c2ok && better(b_v, a_v, r_hs)) ? r_b : r_a;
        is_w1    = (i_cmd.op == OP_W1) || (i_cmd.op == OP_XW1);
        is_w2    = (i_cmd.op == OP_W2);
        out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.empty    = (r_count == '0);
        o_sts.full     = (r_count == CNT_W'(CAPACITY));
        o_sts.up_go    = (r_cur != '0) && ({1'b0, r_cur} < r_count);
        o_sts.dn_go    = (c1 < r_count);
        o_sts.swap_up  = better(a_v, b_v, r_hs);
        o_sts.swap_dn  = better(b_v, a_v, r_hs);
        o_sts.out_free = out_free;
    end

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            val_we[h] = 1'b0;
            val_wa[h] = r_a;
            val_wd[h] = r_value;
            lnk_we[h] = 1'b0;
            lnk_wa[h] = r_a;
            lnk_wd[h] = r_a;
            if (i_cmd.op == OP_INS) begin
                val_we[h] = 1'b1;
                val_wa[h] = r_count[ADDR_W-1:0];
                lnk_we[h] = 1'b1;
                lnk_wa[h] = r_count[ADDR_W-1:0];
                lnk_wd[h] = r_count[ADDR_W-1:0];
            end else if (is_w1 || is_w2) begin
                if (r_hs == 1'(h)) begin
                    val_we[h] = 1'b1;
                    val_wa[h] = is_w1 ? r_a : r_b;
                    val_wd[h] = is_w1 ? r_qbv[h] : r_qav[h];
                    lnk_we[h] = 1'b1;
                    lnk_wa[h] = is_w1 ? r_a : r_b;
                    lnk_wd[h] = is_w1 ? r_qbl[h] : r_qal[h];
                end else begin
                    lnk_we[h] = 1'b1;
                    lnk_wa[h] = is_w1 ? r_qbl[1-h] : r_qal[1-h];
                    lnk_wd[h] = is_w1 ? r_a : r_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int h = 0; h < 2; h++) begin
            if (val_we[h]) begin
                r_val[h][val_wa[h]] <= val_wd[h];
            end
            if (lnk_we[h]) begin
                r_lnk[h][lnk_wa[h]] <= lnk_wd[h];
            end
            if (i_cmd.rd) begin
                r_qav[h] <= r_val[h][r_a];
                r_qbv[h] <= r_val[h][r_b];
                r_qal[h] <= r_lnk[h][r_a];
                r_qbl[h] <= r_lnk[h][r_b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_INS:  r_count <= r_count + CNT_W'(1);
                OP_CLR:  r_count <= '0;
                OP_DEC:  r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind    <= i_kind;
                r_value   <= i_value;
                r_xs      <= (i_kind == KIND_EXT_MAX);
                r_status  <= ST_OK;
                r_removed <= '0;
            end
            OP_INS: begin
                r_cur <= r_count[ADDR_W-1:0];
                r_hs  <= 1'b0;
            end
            OP_FULL:  r_status <= ST_FULL;
            OP_EMPTY: r_status <= ST_EMPTY;
            OP_UPSET: begin
                r_a <= r_cur;
                r_b <= parent;
            end
            OP_DNSET: begin
                r_a    <= c1[ADDR_W-1:0];
                r_b    <= c2[ADDR_W-1:0];
                r_c2ok <= (c2 < {1'b0, r_count});
            end
            OP_PICK: begin
                r_a <= r_cur;
                r_b <= pick;
            end
            OP_XW1: begin
                r_removed <= a_v;
                r_other   <= a_l;
            end
            OP_W2: r_cur <= r_b;
            OP_XSET: begin
                r_hs <= r_xs;
                r_a  <= '0;
                r_b  <= cnt_m1;
            end
            OP_YSET: begin
                r_hs <= !r_xs;
                r_a  <= r_other;
                r_b  <= cnt_m1;
            end
            OP_DEC: begin
                r_hs  <= r_xs;
                r_cur <= '0;
            end
            OP_UPO: begin
                r_hs  <= !r_xs;
                r_cur <= r_other;
            end
            OP_HISET: begin
                r_hs  <= 1'b1;
                r_cur <= cnt_m1;
            end
            OP_TOP: begin
                r_a <= '0;
                r_b <= '0;
            end
            OP_OUT: begin
                r_out_status <= r_status;
                r_out_data   <= RES_W'({(r_count == '0), r_count,
                                        (r_count == '0) ? '0 : r_qav[1],
                                        (r_count == '0) ? '0 : r_qav[0],
                                        r_removed});
            end
            default: r_cur <= r_cur;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;

endmodule

// ===== hdl/dep_ctrl.sv =====
// ----------------------------------------------------------------------------
// dep_ctrl
// Command sequencer: decodes a request and steps the heap swaps and sifts.
// ----------------------------------------------------------------------------
module dep_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dep_pkg::t_dp_sts i_sts,
    output dep_pkg::t_dp_cmd o_cmd
);
    import dep_pkg::*;

    t_state r_state;
    t_state n_state;
    t_stage r_stage;
    t_stage n_stage;
    t_state up_exit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= STG_INS_LOW;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    assign up_exit = (r_stage == STG_INS_LOW) ? S_HI_SET : S_FIN;

    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        unique case (r_state)
            S_IDLE:    if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                case (i_sts.kind) inside
                    KIND_INSERT: begin
                        if (i_sts.full) begin
                            n_state = S_FIN;
                        end else begin
                            n_state = S_UP_SET;
                            n_stage = STG_INS_LOW;
                        end
                    end
                    KIND_EXT_MIN, KIND_EXT_MAX:
                        n_state = i_sts.empty ? S_FIN : S_X_SET;
                    default: n_state = S_FIN;
                endcase
            end
            S_UP_SET:  n_state = i_sts.up_go ? S_UP_RD : up_exit;
            S_UP_RD:   n_state = S_UP_EV;
            S_UP_EV:   n_state = i_sts.swap_up ? S_UP_W2 : up_exit;
            S_UP_W2:   n_state = S_UP_SET;
            S_DN_SET:  n_state = i_sts.dn_go ? S_DN_RD1 : S_UPO;
            S_DN_RD1:  n_state = S_DN_PICK;
            S_DN_PICK: n_state = S_DN_RD2;
            S_DN_RD2:  n_state = S_DN_EV;
            S_DN_EV:   n_state = i_sts.swap_dn ? S_DN_W2 : S_UPO;
            S_DN_W2:   n_state = S_DN_SET;
            S_X_SET:   n_state = S_X_RD;
            S_X_RD:    n_state = S_X_W1;
            S_X_W1:    n_state = S_X_W2;
            S_X_W2:    n_state = S_Y_SET;
            S_Y_SET:   n_state = S_Y_RD;
            S_Y_RD:    n_state = S_Y_W1;
            S_Y_W1:    n_state = S_Y_W2;
            S_Y_W2:    n_state = S_X_DEC;
            S_X_DEC:   n_state = S_DN_SET;
            S_UPO: begin
                n_state = S_UP_SET;
                n_stage = STG_EXT;
            end
            S_HI_SET: begin
                n_state = S_UP_SET;
                n_stage = STG_INS_HIGH;
            end
            S_FIN:     n_state = S_FIN_RD;
            S_FIN_RD:  n_state = S_FIN_OUT;
            S_FIN_OUT: if (i_sts.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NOP;
        o_cmd.rd = 1'b0;
        o_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = OP_LOAD;
            end
            S_DECODE: begin
                case (i_sts.kind) inside
                    KIND_INSERT:
                        o_cmd.op = i_sts.full ? OP_FULL : OP_INS;
                    KIND_EXT_MIN, KIND_EXT_MAX:
                        o_cmd.op = i_sts.empty ? OP_EMPTY : OP_NOP;
                    KIND_CLEAR: o_cmd.op = OP_CLR;
                    default:    o_cmd.op = OP_NOP;
                endcase
            end
            S_UP_SET:  if (i_sts.up_go) o_cmd.op = OP_UPSET;
            S_UP_EV:   if (i_sts.swap_up) o_cmd.op = OP_W1;
            S_UP_W2:   o_cmd.op = OP_W2;
            S_DN_SET:  if (i_sts.dn_go) o_cmd.op = OP_DNSET;
            S_DN_PICK: o_cmd.op = OP_PICK;
            S_DN_EV:   if (i_sts.swap_dn) o_cmd.op = OP_W1;
            S_DN_W2:   o_cmd.op = OP_W2;
            S_X_SET:   o_cmd.op = OP_XSET;
            S_X_W1:    o_cmd.op = OP_XW1;
            S_X_W2:    o_cmd.op = OP_W2;
            S_Y_SET:   o_cmd.op = OP_YSET;
            S_Y_W1:    o_cmd.op = OP_W1;
            S_Y_W2:    o_cmd.op = OP_W2;
            S_X_DEC:   o_cmd.op = OP_DEC;
            S_UPO:     o_cmd.op = OP_UPO;
            S_HI_SET:  o_cmd.op = OP_HISET;
            S_FIN:     o_cmd.op = OP_TOP;
            S_FIN_OUT: if (i_sts.out_free) o_cmd.op = OP_OUT;
            S_UP_RD, S_DN_RD1, S_DN_RD2, S_X_RD, S_Y_RD, S_FIN_RD:
                o_cmd.rd = 1'b1;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== hdl/double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Min-heap and max-heap over the same signed values, cross-linked by slot.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the kind (insert,
// extract min, extract max, clear, query) and tdata the value to insert.
// Each request gives one result on the m_axis channel: tuser carries the
// status, tdata the removed value, current min, current max, count and the
// empty flag.
// One request is in work at a time. A query, clear or rejected request
// passes through the decode state and then the finish, finish-read and output
// states before its result appears; the next request can be accepted in the
// same cycle that the result appears. Insert sifts the new entry up in the min
// heap and then in the max heap. Extract swaps the root with the last entry in
// both heaps, then sifts down from the root and sifts up the linked slot in the
// other heap. Each heap and link memory has a single write port, which allows
// one element move per cycle.
// Reset empties the queue; memory contents are not cleared.
// A stalled receiver holds the result register; the next request is still
// accepted and runs until its own result is ready to load.
// ----------------------------------------------------------------------------
module double_ended_priority_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,  // value
    input  logic [2:0]                  i_s_axis_tuser,  // kind
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // removed_value, current_min, current_max, entry_count, is_empty, zero pad
    output logic [dep_pkg::RES_W-1:0]   o_m_axis_tdata,
    output logic [1:0]                  o_m_axis_tuser   // status
);
    import dep_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dep_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_s_axis_tuser),
        .i_value      (i_s_axis_tdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (o_m_axis_tuser),
        .o_out_data   (o_m_axis_tdata)
    );

endmodule

// ===== hdl/dep_checker.sv =====
// ----------------------------------------------------------------------------
// dep_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dep_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [dep_pkg::RES_W-1:0] o_m_axis_tdata,
    input logic [1:0]                o_m_axis_tuser
);
    import dep_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped under stall");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_EMPTY
                             || o_m_axis_tuser == ST_FULL))
        else $error("bad status");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[107] == (o_m_axis_tdata[106:96] == '0)))
        else $error("empty flag disagrees with count");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[107]
        |-> $signed(o_m_axis_tdata[63:32]) <= $signed(o_m_axis_tdata[95:64]))
        else $error("min above max");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[106:96] <= 11'(CAPACITY))
        else $error("count above capacity");

endmodule

bind double_ended_priority_queue dep_checker u_dep_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the double-ended priority queue against a behavioral predictor.
// ----------------------------------------------------------------------------
// A driver sends insert, extract, clear and query requests from a pending
// queue with random gaps; a monitor takes results with random stalls and
// compares every field with the prediction. Random traffic fills the queue
// to capacity, drains part of it before a clear, and also runs at small occupancy.
// ----------------------------------------------------------------------------
module testbench;
    import dep_pkg::*;

    localparam t_kind KIND_QUERY = 3'd4;
    localparam int    VB = VALUE_BITS;

    typedef struct {
        t_kind             kind;
        logic signed [31:0] value;
    } t_request;

    typedef struct {
        t_status            status;
        logic signed [31:0] removed;
        logic signed [31:0] min_val;
        logic signed [31:0] max_val;
        logic [CNT_W-1:0]   count;
        logic               empty;
    } t_result;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [RES_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    double_ended_priority_queue u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // predictor state: heaps 1-based, links cross-reference slots
    logic signed [VB-1:0] lo_heap [CAPACITY+1];
    logic signed [VB-1:0] hi_heap [CAPACITY+1];
    int lo_link [CAPACITY+1];
    int hi_link [CAPACITY+1];
    int fill;

    t_request pending[$];
    t_result  expected_results[$];
    int errors = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_empty = 0;
    bit hold_off = 0;
    int hold_cnt = 0;
    bit pause_drain = 0;
    longint cycles = 0;
    logic s_tready_q = 0;
    logic m_taken = 0;

    function automatic void swap_lo(int a, int b);
        logic signed [VB-1:0] v;
        int l;
        v = lo_heap[a]; lo_heap[a] = lo_heap[b]; lo_heap[b] = v;
        l = lo_link[a]; lo_link[a] = lo_link[b]; lo_link[b] = l;
        hi_link[lo_link[b]] = b;
        hi_link[lo_link[a]] = a;
    endfunction

    function automatic void swap_hi(int a, int b);
        logic signed [VB-1:0] v;
        int l;
        v = hi_heap[a]; hi_heap[a] = hi_heap[b]; hi_heap[b] = v;
        l = hi_link[a]; hi_link[a] = hi_link[b]; hi_link[b] = l;
        lo_link[hi_link[b]] = b;
        lo_link[hi_link[a]] = a;
    endfunction

    function automatic void lo_up(int p);
        while (p > 1 && p <= fill && lo_heap[p] < lo_heap[p/2]) begin
            swap_lo(p, p/2);
            p = p / 2;
        end
    endfunction

    function automatic void hi_up(int p);
        while (p > 1 && p <= fill && hi_heap[p] > hi_heap[p/2]) begin
            swap_hi(p, p/2);
            p = p / 2;
        end
    endfunction

    function automatic void lo_down(int p);
        int c;
        while (2*p <= fill) begin
            c = 2*p;
            if (c + 1 <= fill && lo_heap[c+1] < lo_heap[c]) c++;
            if (!(lo_heap[c] < lo_heap[p])) break;
            swap_lo(p, c);
            p = c;
        end
    endfunction

    function automatic void hi_down(int p);
        int c;
        while (2*p <= fill) begin
            c = 2*p;
            if (c + 1 <= fill && hi_heap[c+1] > hi_heap[c]) c++;
            if (!(hi_heap[c] > hi_heap[p])) break;
            swap_hi(p, c);
            p = c;
        end
    endfunction

    function automatic t_result queue_step(t_request rq);
        t_result r;
        int other;
        r.status = ST_OK;
        r.removed = 0;
        if (rq.kind == KIND_INSERT) begin
            if (fill >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                fill++;
                lo_heap[fill] = rq.value[VB-1:0];
                hi_heap[fill] = rq.value[VB-1:0];
                lo_link[fill] = fill;
                hi_link[fill] = fill;
                lo_up(fill);
                hi_up(fill);
            end
        end else if (rq.kind == KIND_EXT_MIN || rq.kind == KIND_EXT_MAX) begin
            if (fill == 0) begin
                r.status = ST_EMPTY;
            end else if (rq.kind == KIND_EXT_MIN) begin
                other = lo_link[1];
                r.removed = lo_heap[1];
                swap_lo(1, fill);
                swap_hi(other, fill);
                fill--;
                lo_down(1);
                hi_up(other);
            end else begin
                other = hi_link[1];
                r.removed = hi_heap[1];
                swap_hi(1, fill);
                swap_lo(other, fill);
                fill--;
                hi_down(1);
                lo_up(other);
            end
        end else if (rq.kind == KIND_CLEAR) begin
            fill = 0;
        end
        r.min_val = fill ? 32'(lo_heap[1]) : 0;
        r.max_val = fill ? 32'(hi_heap[1]) : 0;
        r.count = CNT_W'(fill);
        r.empty = (fill == 0);
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push(t_kind k, logic [31:0] v);
        t_request rq;
        rq.kind = k;
        rq.value = v;
        pending.insert(pending.size(), rq);
    endfunction

    // driver
    int gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready_q) begin
                s_tvalid <= 0;
                gap = $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end else if (!s_tvalid) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending.size() > 0 && !(pause_drain && expected_results.size())) begin
                    s_tvalid <= 1;
                    s_tuser <= pending[0].kind;
                    s_tdata <= pending[0].value;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        s_tready_q <= 0;
        if (i_rst_n && s_tvalid && s_tready) begin
            s_tready_q <= 1;
            expected_results.insert(expected_results.size(), queue_step(pending.pop_front()));
        end
    end

    // receiver hold-off length
    always @(posedge i_clk) begin
        if (hold_off) begin
            hold_cnt++;
            if (hold_cnt >= 400) hold_off <= 0;
        end
    end

    // monitor
    int stall = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off) begin
                m_tready <= 0;
            end else if (m_tready && m_taken) begin
                stall = $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0) stall = 0;
                m_tready <= (stall == 0);
            end else if (stall > 0) begin
                stall--;
                m_tready <= (stall == 0);
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        t_result g;
        cycles++;
        m_taken <= 0;
        if (i_rst_n && m_tvalid && m_tready) begin
            m_taken <= 1;
            {g.empty, g.count, g.max_val, g.min_val, g.removed} =
                m_tdata[RES_BITS-1:0];
            g.status = m_tuser;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (e.status == ST_FULL) n_full++;
                if (e.status == ST_EMPTY) n_empty++;
                if (g.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, g.status); errors++;
                end
                if (g.removed !== e.removed) begin
                    $error("removed_value exp %0d got %0d", e.removed, g.removed); errors++;
                end
                if (g.min_val !== e.min_val) begin
                    $error("current_min exp %0d got %0d", e.min_val, g.min_val); errors++;
                end
                if (g.max_val !== e.max_val) begin
                    $error("current_max exp %0d got %0d", e.max_val, g.max_val); errors++;
                end
                if (g.count !== e.count) begin
                    $error("entry_count exp %0d got %0d", e.count, g.count); errors++;
                end
                if (g.empty !== e.empty) begin
                    $error("is_empty exp %0d got %0d", e.empty, g.empty); errors++;
                end
            end
        end
        if (cycles > 2000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending.size() || expected_results.size() || s_tvalid) @(posedge i_clk);
    endtask

    int k;
    initial begin
        fill = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;
        // directed: empty extracts, extremes, ties, clear, query, unused kinds
        push(KIND_EXT_MIN, 0); push(KIND_EXT_MAX, 0); push(KIND_QUERY, 0);
        push(KIND_INSERT, 32'h7fff_ffff); push(KIND_INSERT, 32'h8000_0000);
        push(KIND_INSERT, 0); push(KIND_INSERT, 32'hffff_ffff);
        push(KIND_INSERT, 5); push(KIND_INSERT, 5); push(KIND_INSERT, 32'h5555_aaaa);
        push(KIND_EXT_MIN, 0); push(KIND_EXT_MAX, 0); push(KIND_EXT_MIN, 0);
        push(3'd5, 0); push(3'd6, 0); push(3'd7, 32'hffff_ffff);
        push(KIND_CLEAR, 0); push(KIND_EXT_MAX, 0); push(KIND_INSERT, 1);
        push(KIND_EXT_MAX, 0);
        wait_drained();
        // long receiver hold-off while requests keep arriving
        hold_cnt = 0;
        hold_off = 1;
        for (k = 0; k < 60; k++) push(KIND_INSERT, rand_value());
        wait_drained();
        // fill to capacity and beyond, with extracts mixed in
        pause_drain = 1;
        for (k = 0; k < CAPACITY; k++) begin
            if ($urandom_range(0, 7) == 0) push(t_kind'($urandom_range(1, 2)), 0);
            else push(KIND_INSERT, rand_value());
            if (k % 200 == 0) begin
                wait_drained();
                pause_drain = (k < 400);
            end
        end
        while (fill < CAPACITY) begin
            push(KIND_INSERT, rand_value());
            wait_drained();
        end
        push(KIND_INSERT, 32'h1234_5678); push(KIND_INSERT, 32'h8000_0000);
        wait_drained();
        // drain toward empty
        for (k = 0; k < 300; k++) push(t_kind'($urandom_range(1, 2)), rand_value());
        push(KIND_CLEAR, 0);
        // small occupancy random mix
        for (k = 0; k < 50; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push(KIND_INSERT, rand_value());
                4, 5: push(KIND_EXT_MIN, rand_value());
                6, 7: push(KIND_EXT_MAX, rand_value());
                8: push(($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_QUERY, rand_value());
                default: push(t_kind'($urandom_range(4, 7)), rand_value());
            endcase
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("Checked %0d results, %0d full rejects, %0d empty extracts.",
                 n_checked, n_full, n_empty);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/dep_pkg.sv
hdl/dep_datapath.sv
hdl/dep_ctrl.sv
hdl/double_ended_priority_queue.sv
hdl/dep_checker.sv
test/testbench.sv
